[hdl/rmd128_pkg.sv]
package rmd128_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_PRE,
        S_COMP,
        S_MERGE,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        P_FIRST,
        P_ZERO,
        P_LEN
    } t_phase;

    localparam logic [31:0] C_H0 = 32'h67452301;
    localparam logic [31:0] C_H1 = 32'hefcdab89;
    localparam logic [31:0] C_H2 = 32'h98badcfe;
    localparam logic [31:0] C_H3 = 32'h10325476;

    localparam logic [31:0] C_KL [4] = '{32'h00000000, 32'h5a827999,
                                         32'h6ed9eba1, 32'h8f1bbcdc};
    localparam logic [31:0] C_KR [4] = '{32'h50a28be6, 32'h5c4dd124,
                                         32'h6d703ef3, 32'h00000000};

    localparam logic [3:0] C_SEL_L [64] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
        4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
        4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
        4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
        4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
        4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2};

    localparam logic [3:0] C_SEL_R [64] = '{
        4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
        4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
        4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
        4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
        4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
        4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
        4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
        4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14};

    localparam logic [3:0] C_ROT_L [64] = '{
        4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
        4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
        4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
        4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
        4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
        4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
        4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
        4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12};

    localparam logic [3:0] C_ROT_R [64] = '{
        4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
        4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
        4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
        4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
        4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
        4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
        4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
        4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8};

    function automatic logic [31:0] fsel(input logic [1:0] k, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z);
        logic [31:0] f;
        case (k)
            2'd0:    f = x ^ y ^ z;
            2'd1:    f = (x & y) | (~x & z);
            2'd2:    f = (x | ~y) ^ z;
            default: f = (x & z) | (y & ~z);
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [3:0] n);
        logic [63:0] t;
        t = {v, v} << n;
        return t[63:32];
    endfunction

endpackage

[hdl/rmd128_front.sv]
module rmd128_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_has_byte,
    input  logic                 i_last,
    output logic                 o_q_valid,
    output rmd128_pkg::t_item    o_q_item,
    input  logic                 i_q_pop
);
    import rmd128_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{data_byte: i_data_byte, has_byte: i_has_byte, last: i_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[hdl/rmd128_core.sv]
module rmd128_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  rmd128_pkg::t_item    i_q_item,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [63:0]          o_digest_low,
    output logic [63:0]          o_digest_high
);
    import rmd128_pkg::*;

    t_state      r_state;
    t_state      n_state;
    t_phase      r_phase;
    logic        r_fin;
    logic [63:0] r_cnt;
    logic [63:0] r_bits;
    logic [23:0] r_acc;
    logic [31:0] r_mem [16];
    logic [31:0] r_xl;
    logic [31:0] r_xr;
    logic [5:0]  r_step;
    logic [31:0] r_h0, r_h1, r_h2, r_h3;
    logic [31:0] r_al, r_bl, r_cl, r_dl;
    logic [31:0] r_ar, r_br, r_cr, r_dr;
    logic        r_ovalid;
    logic [63:0] r_dlow;
    logic [63:0] r_dhigh;

    logic [5:0]  pos;
    logic [5:0]  pos_nx;
    logic        wr_en;
    logic [7:0]  wr_byte;
    logic [5:0]  step_nx;
    logic [3:0]  rd_l;
    logic [3:0]  rd_r;
    logic [1:0]  rnd;
    logic [31:0] tl;
    logic [31:0] tr;
    logic        load;

    assign pos     = r_cnt[5:0];
    assign pos_nx  = pos + 6'd1;
    assign step_nx = r_step + 6'd1;
    assign rnd     = r_step[5:4];
    assign load    = (r_state == S_EMIT) && (!r_ovalid || !i_stall);
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    assign o_valid       = r_ovalid;
    assign o_digest_low  = r_dlow;
    assign o_digest_high = r_dhigh;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.has_byte && pos == 6'd63) begin
                        n_state = S_PRE;
                    end else if (i_q_item.last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (pos == 6'd63) begin
                    n_state = S_PRE;
                end
            end
            S_PRE:  n_state = S_COMP;
            S_COMP: begin
                if (r_step == 6'd63) begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (r_fin) begin
                    n_state = (r_phase == P_LEN) ? S_EMIT : S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_byte = 8'h00;
        rd_l    = C_SEL_L[0];
        rd_r    = C_SEL_R[0];
        unique case (r_state)
            S_IDLE: begin
                wr_en   = i_q_valid && i_q_item.has_byte;
                wr_byte = i_q_item.data_byte;
            end
            S_PAD: begin
                wr_en = 1'b1;
                unique case (r_phase)
                    P_FIRST: wr_byte = 8'h80;
                    P_LEN:   wr_byte = r_bits[{pos[2:0], 3'b000} +: 8];
                    default: wr_byte = 8'h00;
                endcase
            end
            S_COMP: begin
                rd_l = C_SEL_L[step_nx];
                rd_r = C_SEL_R[step_nx];
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign tl = rotl(r_al + fsel(rnd, r_bl, r_cl, r_dl) + r_xl + C_KL[rnd], C_ROT_L[r_step]);
    assign tr = rotl(r_ar + fsel(~rnd, r_br, r_cr, r_dr) + r_xr + C_KR[rnd], C_ROT_R[r_step]);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            case (pos[1:0])
                2'd0:    r_acc[7:0]   <= wr_byte;
                2'd1:    r_acc[15:8]  <= wr_byte;
                2'd2:    r_acc[23:16] <= wr_byte;
                default: r_mem[pos[5:2]] <= {wr_byte, r_acc};
            endcase
        end
        r_xl <= r_mem[rd_l];
        r_xr <= r_mem[rd_r];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PRE) begin
            r_al <= r_h0; r_bl <= r_h1; r_cl <= r_h2; r_dl <= r_h3;
            r_ar <= r_h0; r_br <= r_h1; r_cr <= r_h2; r_dr <= r_h3;
        end else if (r_state == S_COMP) begin
            r_al <= r_dl; r_dl <= r_cl; r_cl <= r_bl; r_bl <= tl;
            r_ar <= r_dr; r_dr <= r_cr; r_cr <= r_br; r_br <= tr;
        end
        if (load) begin
            r_dlow  <= {r_h1, r_h0};
            r_dhigh <= {r_h3, r_h2};
        end
        if (o_q_pop && i_q_item.last) begin
            r_bits <= (r_cnt + {63'd0, i_q_item.has_byte}) << 3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= P_FIRST;
            r_fin    <= 1'b0;
            r_cnt    <= 64'd0;
            r_step   <= 6'd0;
            r_ovalid <= 1'b0;
            r_h0     <= C_H0;
            r_h1     <= C_H1;
            r_h2     <= C_H2;
            r_h3     <= C_H3;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_cnt <= r_cnt + 64'd1;
            end
            if (o_q_pop && i_q_item.last) begin
                r_fin   <= 1'b1;
                r_phase <= P_FIRST;
            end
            if (r_state == S_PAD) begin
                if (r_phase != P_LEN) begin
                    r_phase <= (pos_nx == 6'd56) ? P_LEN : P_ZERO;
                end
            end
            if (r_state == S_PRE) begin
                r_step <= 6'd0;
            end else if (r_state == S_COMP) begin
                r_step <= step_nx;
            end
            if (r_state == S_MERGE) begin
                r_h0 <= r_h1 + r_cl + r_dr;
                r_h1 <= r_h2 + r_dl + r_ar;
                r_h2 <= r_h3 + r_al + r_br;
                r_h3 <= r_h0 + r_bl + r_cr;
            end
            if (load) begin
                r_ovalid <= 1'b1;
                r_fin    <= 1'b0;
                r_cnt    <= 64'd0;
                r_h0     <= C_H0;
                r_h1     <= C_H1;
                r_h2     <= C_H2;
                r_h3     <= C_H3;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

[hdl/ripemd128_hash.sv]
// RIPEMD-128 over a byte stream. Items enter a two-entry queue and are drained one per cycle
// while the core is idle and bytes are written to the block store; each full 64-byte block
// then takes a prefetch, 64 rounds of the paired left and right lines, and a merge, during
// which the queue is not drained. An item with last set adds the padding bytes at one per
// cycle, one or two compressions and a load of the digest register. The digest stays in its
// output register until taken, while the queue accepts items until its two entries are full.
module ripemd128_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_low,
    output logic [63:0] o_digest_high
);
    import rmd128_pkg::*;

    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    rmd128_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_has_byte  (i_has_byte),
        .i_last      (i_last),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    rmd128_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_low  (o_digest_low),
        .o_digest_high (o_digest_high)
    );

endmodule
